// ===== rtl/qph_pkg.sv =====
// Shared types and constants of the quadratic-probe hash table.
`timescale 1ns / 1ps
`default_nettype none

package qph_pkg;

    // Fixed widths of the item fields and the size register
    localparam int unsigned MODE_W  = 1;
    localparam int unsigned KEYIN_W = 20;
    localparam int unsigned CFG_W   = 14;
    localparam int unsigned COUNT_W = 14;
    localparam int unsigned SLOT_W  = 13;

    // Size register reset value and lower clamp
    localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 14'd8191;
    localparam int unsigned      MIN_SIZE         = 2;

    // Key bits consumed per cycle by the remainder unit
    localparam int unsigned MOD_BITS = 4;

    // Operation codes of an input item
    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 1'b0,
        MODE_SEARCH = 1'b1
    } t_mode;

    // Result status codes
    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_FULL      = 2'd1,
        ST_FOUND     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Outcome chosen by the controller when a result is loaded
    typedef enum logic [2:0] {
        RK_INS_OK     = 3'd0,
        RK_INS_FAIL   = 3'd1,
        RK_FOUND      = 3'd2,
        RK_MISS_EMPTY = 3'd3,
        RK_MISS_ALL   = 3'd4,
        RK_MISS_ZERO  = 3'd5
    } t_res_kind;

    typedef struct packed {
        t_mode                mode;
        logic [KEYIN_W-1:0]   key_value;
    } t_in_item;

    typedef struct packed {
        t_status              status;
        logic [COUNT_W-1:0]   probe_count;
        logic [SLOT_W-1:0]    slot_index;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic      clear;
        logic      accept;
        logic      probe_init;
        logic      probe_run;
        logic      ins_write;
        logic      res_load;
        t_res_kind res_kind;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic in_key_zero;
        logic in_search;
        logic mod_done;
        logic chk_valid;
        logic chk_hit;
        logic chk_found;
        logic chk_last;
        logic search;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/qph_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module qph_ram #(
    parameter int unsigned WIDTH = 20,
    parameter int unsigned DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/qph_mod.sv =====
// Iterative remainder unit: key mod size, MOD_BITS key bits per cycle.
`timescale 1ns / 1ps
`default_nettype none

module qph_mod #(
    parameter int unsigned KEY_WIDTH = 20,
    parameter int unsigned SIZE_W    = 14
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [KEY_WIDTH-1:0] i_key,
    input  wire logic [SIZE_W-1:0]    i_size,
    output logic                      o_done,
    output logic      [SIZE_W-1:0]    o_rem
);

    import qph_pkg::*;

    localparam int unsigned MOD_CYC = (KEY_WIDTH + MOD_BITS - 1) / MOD_BITS;
    localparam int unsigned KEY_PAD = MOD_CYC * MOD_BITS;
    localparam int unsigned CYC_W   = $clog2(MOD_CYC + 1);

    logic [KEY_PAD-1:0] r_key;
    logic [SIZE_W-1:0]  r_rem;
    logic [SIZE_W-1:0]  n_rem;
    logic [CYC_W-1:0]   r_cnt;
    logic               r_done;

    // MOD_BITS restoring steps, key taken MSB first
    always_comb begin
        logic [SIZE_W:0] v_t;
        n_rem = r_rem;
        for (int k = 0; k < MOD_BITS; k++) begin
            v_t = {n_rem, r_key[KEY_PAD-1-k]};
            if (v_t >= {1'b0, i_size}) begin
                v_t = v_t - {1'b0, i_size};
            end
            n_rem = v_t[SIZE_W-1:0];
        end
    end

    // Step counter and operand shift register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_key  <= KEY_PAD'(i_key);
            r_rem  <= '0;
            r_cnt  <= CYC_W'(MOD_CYC);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_key  <= r_key << MOD_BITS;
            r_rem  <= n_rem;
            r_cnt  <= r_cnt - CYC_W'(1);
            r_done <= (r_cnt == CYC_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== rtl/qph_datapath.sv =====
// Datapath: size register, key store, probe sequence and result register.
`timescale 1ns / 1ps
`default_nettype none

module qph_datapath #(
    parameter int unsigned TABLE_DEPTH = 8192,
    parameter int unsigned KEY_WIDTH   = 20
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [qph_pkg::CFG_W-1:0] i_cfg_wdata,
    input  wire qph_pkg::t_in_item         i_item,
    input  wire qph_pkg::t_cmd             i_cmd,
    output qph_pkg::t_stat                 o_stat,
    output qph_pkg::t_out_item             o_result
);

    import qph_pkg::*;

    localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
    localparam int unsigned SIZE_W = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 2);
    localparam int unsigned SUM_W  = ADDR_W + 2;

    logic [CFG_W-1:0]     r_cfg_size;
    logic [SIZE_W-1:0]    eff_size;
    logic [SIZE_W-1:0]    r_size;
    logic [KEY_WIDTH-1:0] r_key;
    t_mode                r_mode;
    logic [ADDR_W-1:0]    r_clr_addr;
    logic [ADDR_W-1:0]    r_slot;
    logic [ADDR_W-1:0]    n_slot;
    logic [ADDR_W-1:0]    r_step;
    logic [ADDR_W-1:0]    n_step;
    logic [CNT_W-1:0]     r_issue_cnt;
    logic                 r_chk_valid;
    logic [ADDR_W-1:0]    r_chk_slot;
    logic [CNT_W-1:0]     r_chk_cnt;
    t_out_item            r_result;
    t_out_item            n_result;

    logic [31:0]          in_key_ext;
    logic [KEY_WIDTH-1:0] in_key;
    logic                 mod_done;
    logic [SIZE_W-1:0]    mod_rem;
    logic                 issue;
    logic [KEY_WIDTH-1:0] rd_data;
    logic                 rd_match;
    logic                 rd_empty;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [KEY_WIDTH-1:0] mem_wdata;
    logic [SUM_W-1:0]     slot_sum;
    logic [SUM_W-1:0]     step_sum;
    logic [SUM_W-1:0]     size_ext;

    // Size register; the user is to write it only while idle, the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_size <= TABLE_SIZE_RESET;
        end else if (i_cfg_we) begin
            r_cfg_size <= i_cfg_wdata;
        end
    end

    // Clamp size to [2, TABLE_DEPTH]
    always_comb begin
        if (32'(r_cfg_size) < 32'(MIN_SIZE)) begin
            eff_size = SIZE_W'(MIN_SIZE);
        end else if (32'(r_cfg_size) > 32'(TABLE_DEPTH)) begin
            eff_size = SIZE_W'(TABLE_DEPTH);
        end else begin
            eff_size = SIZE_W'(r_cfg_size);
        end
    end

    // Incoming key, masked to KEY_WIDTH
    assign in_key_ext = 32'(i_item.key_value);
    assign in_key     = in_key_ext[KEY_WIDTH-1:0];

    // Item registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_key  <= in_key;
            r_mode <= i_item.mode;
            r_size <= eff_size;
        end
    end

    // Start slot: key mod size
    qph_mod #(
        .KEY_WIDTH (KEY_WIDTH),
        .SIZE_W    (SIZE_W)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.accept),
        .i_key   (in_key),
        .i_size  (r_size),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    // Next slot adds the odd step 2i+1, both kept below size
    assign size_ext = SUM_W'(r_size);
    assign slot_sum = SUM_W'(r_slot) + SUM_W'(r_step);
    assign step_sum = SUM_W'(r_step) + SUM_W'(MIN_SIZE);

    always_comb begin
        logic [SUM_W-1:0] v_slot;
        logic [SUM_W-1:0] v_step;
        v_slot = (slot_sum >= size_ext) ? slot_sum - size_ext : slot_sum;
        v_step = (step_sum >= size_ext) ? step_sum - size_ext : step_sum;
        n_slot = v_slot[ADDR_W-1:0];
        n_step = v_step[ADDR_W-1:0];
    end

    assign issue = i_cmd.probe_run && (r_issue_cnt < CNT_W'(r_size));

    // Probe issue and check stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_valid <= 1'b0;
        end else if (i_cmd.probe_init) begin
            r_chk_valid <= 1'b0;
        end else begin
            r_chk_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.probe_init) begin
            r_slot      <= ADDR_W'(mod_rem);
            r_step      <= ADDR_W'(1);
            r_issue_cnt <= '0;
        end else if (issue) begin
            r_slot      <= n_slot;
            r_step      <= n_step;
            r_issue_cnt <= r_issue_cnt + CNT_W'(1);
            r_chk_slot  <= r_slot;
            r_chk_cnt   <= r_issue_cnt + CNT_W'(1);
        end
    end

    // Clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    // Key store
    assign mem_we    = i_cmd.clear || i_cmd.ins_write;
    assign mem_waddr = i_cmd.clear ? r_clr_addr : r_chk_slot;
    assign mem_wdata = i_cmd.clear ? '0 : r_key;

    qph_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (issue),
        .i_raddr (r_slot),
        .o_rdata (rd_data)
    );

    assign rd_match = (rd_data == r_key);
    assign rd_empty = (rd_data == '0);

    // Status to the controller
    always_comb begin
        o_stat.clr_last    = (r_clr_addr == ADDR_W'(TABLE_DEPTH - 1));
        o_stat.in_key_zero = (in_key == '0);
        o_stat.in_search   = (i_item.mode == MODE_SEARCH);
        o_stat.mod_done    = mod_done;
        o_stat.chk_valid   = r_chk_valid;
        o_stat.chk_found   = rd_match;
        o_stat.chk_hit     = (r_mode == MODE_SEARCH) ? (rd_match || rd_empty) : rd_empty;
        o_stat.chk_last    = (r_chk_cnt == CNT_W'(r_size));
        o_stat.search      = (r_mode == MODE_SEARCH);
    end

    // Result fields per outcome
    always_comb begin
        n_result = '0;
        case (i_cmd.res_kind)
            RK_INS_OK: begin
                n_result.status     = ST_INSERTED;
                n_result.slot_index = SLOT_W'(r_chk_slot);
            end
            RK_FOUND: begin
                n_result.status      = ST_FOUND;
                n_result.probe_count = COUNT_W'(r_chk_cnt);
                n_result.slot_index  = SLOT_W'(r_chk_slot);
            end
            RK_MISS_EMPTY: begin
                n_result.status      = ST_NOT_FOUND;
                n_result.probe_count = COUNT_W'(r_chk_cnt);
            end
            RK_MISS_ALL: begin
                n_result.status      = ST_NOT_FOUND;
                n_result.probe_count = COUNT_W'(CNT_W'(r_size) + CNT_W'(1));
            end
            RK_MISS_ZERO: begin
                n_result.status      = ST_NOT_FOUND;
                n_result.probe_count = COUNT_W'(1);
            end
            default: begin
                n_result.status = ST_FULL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== rtl/qph_ctrl.sv =====
// Controller: clearing pass, item sequencing and result strobe.
`timescale 1ns / 1ps
`default_nettype none

module qph_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire qph_pkg::t_stat i_stat,
    output qph_pkg::t_cmd       o_cmd,
    output logic                o_strobe
);

    import qph_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_MOD   = 4'b0100,
        S_PROBE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_strobe;

    // Next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.res_kind = RK_INS_FAIL;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    if (i_stat.in_key_zero) begin
                        // zero key is answered at once
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_kind = i_stat.in_search ? RK_MISS_ZERO : RK_INS_FAIL;
                    end else begin
                        o_cmd.accept = 1'b1;
                        n_state      = S_MOD;
                    end
                end
            end
            S_MOD: begin
                if (i_stat.mod_done) begin
                    o_cmd.probe_init = 1'b1;
                    n_state          = S_PROBE;
                end
            end
            S_PROBE: begin
                if (i_stat.chk_valid && i_stat.chk_hit) begin
                    o_cmd.res_load = 1'b1;
                    if (i_stat.search) begin
                        o_cmd.res_kind = i_stat.chk_found ? RK_FOUND : RK_MISS_EMPTY;
                    end else begin
                        o_cmd.res_kind  = RK_INS_OK;
                        o_cmd.ins_write = 1'b1;
                    end
                    n_state = S_IDLE;
                end else if (i_stat.chk_valid && i_stat.chk_last) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_kind = i_stat.search ? RK_MISS_ALL : RK_INS_FAIL;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.probe_run = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and strobe registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= o_cmd.res_load;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;

endmodule

`default_nettype wire

// ===== rtl/quadratic_probe_hash_table.sv =====
// Top level of the quadratic-probe hash table.
// Open-addressed table of positive keys; probe i of a key visits slot
// (key + i*i) mod table_size. After reset the store is swept to empty, one
// slot a cycle with busy high; the size register may be written during that
// sweep. An item is taken when start is high and busy is low. A zero key is
// answered without going busy. Otherwise the start slot comes from an
// iterative remainder unit, after which the probe walk reads one slot of the
// single-read-port store per cycle. Each result is loaded into o_result and
// marked by o_strobe for one cycle, in the cycle after the last probe is
// checked; it cannot be held off, and the next item may be started while it
// is shown.
`timescale 1ns / 1ps
`default_nettype none

module quadratic_probe_hash_table #(
    parameter int unsigned TABLE_DEPTH = 8192,
    parameter int unsigned KEY_WIDTH   = 20
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire qph_pkg::t_in_item         i_item,
    output logic                           o_strobe,
    output qph_pkg::t_out_item             o_result,
    input  wire logic                      i_cfg_we,
    input  wire logic [qph_pkg::CFG_W-1:0] i_cfg_wdata
);

    import qph_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    qph_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_strobe (o_strobe)
    );

    qph_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

// ===== test/quadratic_probe_hash_table_test.sv =====
// Self-checking testbench for the quadratic-probe hash table: queued items, scoreboard check.
`timescale 1ns / 1ps

module quadratic_probe_hash_table_test;

    import qph_pkg::*;

    localparam int unsigned SLOT_DEPTH   = 8192;
    localparam int unsigned KEY_MAX      = 'hFFFFF;
    localparam int unsigned SETTLE_TICKS = 20;
    localparam int unsigned CYCLE_LIMIT  = 60_000_000;
    localparam int unsigned REPORT_MAX   = 10;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 start     = 1'b0;
    logic                 busy;
    t_in_item             drv_item  = '0;
    logic                 result_strobe;
    t_out_item            result_bus;
    logic                 cfg_we    = 1'b0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // Shadow of the block: slot store and size register
    logic [KEYIN_W-1:0]   shadow_slots [SLOT_DEPTH];
    logic [CFG_W-1:0]     shadow_size = TABLE_SIZE_RESET;

    t_in_item             pending_items [$];
    t_out_item            expected_results [$];
    int unsigned          placed_keys [$];
    int unsigned          idle_pct    = 0;
    int unsigned          fail_count  = 0;
    int unsigned          cycle_count = 0;

    quadratic_probe_hash_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (drv_item),
        .o_strobe    (result_strobe),
        .o_result    (result_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        foreach (shadow_slots[n]) shadow_slots[n] = '0;
    end

    // Size actually in use once the register is clamped
    function automatic int unsigned active_slots(logic [CFG_W-1:0] v);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > SLOT_DEPTH) return SLOT_DEPTH;
        return 32'(v);
    endfunction

    // Walk the probe sequence on the shadow store and form the result
    function automatic t_out_item probe_walk(t_in_item it);
        t_out_item   r;
        int unsigned n;
        int unsigned key;
        int unsigned slot;
        int unsigned i;
        r   = '0;
        n   = active_slots(shadow_size);
        key = 32'(it.key_value);
        if (it.mode == MODE_INSERT) begin
            r.status = ST_FULL;
            if (key != 0) begin
                for (i = 0; i < n; i++) begin
                    slot = (key + i * i) % n;
                    if (shadow_slots[slot] == '0) begin
                        shadow_slots[slot] = KEYIN_W'(key);
                        r.status     = ST_INSERTED;
                        r.slot_index = SLOT_W'(slot);
                        break;
                    end
                end
            end
        end else begin
            r.status = ST_NOT_FOUND;
            if (key == 0) begin
                r.probe_count = COUNT_W'(1);
            end else begin
                // no key and no empty slot met: every probe used up
                r.probe_count = COUNT_W'(n + 1);
                for (i = 0; i < n; i++) begin
                    slot = (key + i * i) % n;
                    if (shadow_slots[slot] == KEYIN_W'(key)) begin
                        r.status      = ST_FOUND;
                        r.slot_index  = SLOT_W'(slot);
                        r.probe_count = COUNT_W'(i + 1);
                        break;
                    end
                    if (shadow_slots[slot] == '0) begin
                        r.probe_count = COUNT_W'(i + 1);
                        break;
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX) $display("%0t: %s", $time, msg);
    endtask

    task automatic queue_item(input t_mode m, input int unsigned key);
        t_in_item it;
        it.mode      = m;
        it.key_value = KEYIN_W'(key);
        pending_items.push_back(it);
        if (m == MODE_INSERT && key != 0) placed_keys.push_back(key);
    endtask

    function automatic int unsigned any_key();
        int unsigned roll;
        roll = $urandom_range(19);
        if (roll == 0) return 1;
        if (roll == 1) return KEY_MAX;
        return $urandom_range(KEY_MAX, 1);
    endfunction

    function automatic int unsigned known_key();
        if (placed_keys.size() == 0) return any_key();
        return placed_keys[$urandom_range(placed_keys.size() - 1)];
    endfunction

    // Mostly inserts and searches of stored keys, some colliding keys, some noise
    task automatic queue_random_items(input int unsigned count);
        int unsigned j;
        int unsigned roll;
        int unsigned base;
        int unsigned step;
        for (j = 0; j < count; j++) begin
            roll = $urandom_range(99);
            if (roll < 38) begin
                queue_item(MODE_INSERT, any_key());
            end else if (roll < 50) begin
                // same start slot as a stored key, to build probe chains
                base = known_key();
                step = active_slots(shadow_size) * $urandom_range(3, 1);
                if (base + step <= KEY_MAX) queue_item(MODE_INSERT, base + step);
                else if (base > step) queue_item(MODE_INSERT, base - step);
                else queue_item(MODE_INSERT, any_key());
            end else if (roll < 55) begin
                queue_item(MODE_INSERT, known_key());
            end else if (roll < 85) begin
                queue_item(MODE_SEARCH, known_key());
            end else if (roll < 95) begin
                queue_item(MODE_SEARCH, any_key());
            end else begin
                queue_item($urandom_range(1) ? MODE_SEARCH : MODE_INSERT, 0);
            end
        end
    endtask

    // Wait until every item is taken and answered, then let the block settle
    task automatic drain();
        while (pending_items.size() != 0 || start || expected_results.size() != 0 || busy)
            @(negedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_size(input int unsigned v);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= CFG_W'(v);
        @(posedge i_clk);
        cfg_we      <= 1'b0;
        shadow_size  = CFG_W'(v);
    endtask

    task automatic run_phase(input int unsigned size, input int unsigned count,
                             input int unsigned idle);
        drain();
        write_size(size);
        idle_pct = idle;
        queue_random_items(count);
    endtask

    // Item driver: hold an item until taken, random gaps between items
    always @(posedge i_clk) begin : item_driver
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) expected_results.push_back(probe_walk(drv_item));
            if (start && busy) begin
                // held until the block takes it
            end else if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
                start    <= 1'b1;
                drv_item <= pending_items.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Result check against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && result_strobe === 1'b1) begin
            if (expected_results.size() == 0) begin
                note_failure($sformatf("unexpected result: status %0d count %0d slot %0d",
                                       result_bus.status, result_bus.probe_count,
                                       result_bus.slot_index));
            end else begin
                want = expected_results.pop_front();
                if (result_bus.status !== want.status
                        || result_bus.probe_count !== want.probe_count
                        || result_bus.slot_index !== want.slot_index)
                    note_failure($sformatf(
                        "mismatch: expected status %0d count %0d slot %0d, got %0d %0d %0d",
                        want.status, want.probe_count, want.slot_index,
                        result_bus.status, result_bus.probe_count, result_bus.slot_index));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("quadratic_probe_hash_table_test: done, errors");
            $finish;
        end
    end

    initial begin : sequencer
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes of the key, zero keys, duplicates, probe chains
        idle_pct = 0;
        queue_item(MODE_INSERT, KEY_MAX);
        queue_item(MODE_INSERT, 1);
        queue_item(MODE_INSERT, 0);
        queue_item(MODE_SEARCH, 0);
        queue_item(MODE_SEARCH, KEY_MAX);
        queue_item(MODE_SEARCH, 1);
        queue_item(MODE_SEARCH, 2);
        queue_item(MODE_INSERT, 1);
        queue_item(MODE_SEARCH, 1);
        queue_item(MODE_INSERT, 100);
        queue_item(MODE_INSERT, 100 + 8191);
        queue_item(MODE_INSERT, 100 + 2 * 8191);
        queue_item(MODE_SEARCH, 100 + 2 * 8191);
        queue_item(MODE_SEARCH, 100 + 3 * 8191);
        queue_item(MODE_INSERT, 20'h55555);
        queue_item(MODE_INSERT, 20'hAAAAA);
        queue_item(MODE_SEARCH, 20'h55555);
        queue_item(MODE_SEARCH, 20'hAAAAA);

        // Tiny table: fill the reachable slots, then a failing insert and an
        // exhausted search
        drain();
        write_size(7);
        queue_item(MODE_INSERT, 7);
        queue_item(MODE_INSERT, 14);
        queue_item(MODE_INSERT, 21);
        queue_item(MODE_INSERT, 28);
        queue_item(MODE_SEARCH, 35);
        queue_item(MODE_SEARCH, 14);

        // Random phases over sizes, clamps and sender gaps
        run_phase(8191,  100, 0);
        run_phase(13,     60, 80);
        run_phase(0,      40, 0);
        run_phase(1021,  100, 35);
        run_phase(16383, 100, 0);
        run_phase(7,      60, 80);
        run_phase(8192,   80, 35);
        run_phase(5,      50, 0);
        run_phase(4093,  100, 80);
        run_phase(1,      40, 35);
        run_phase(8193,   80, 0);
        run_phase(101,    80, 35);
        run_phase(3,      40, 80);
        run_phase(10922,  80, 0);
        run_phase(8191,   70, 35);

        drain();
        if (fail_count == 0 && expected_results.size() == 0)
            $display("quadratic_probe_hash_table_test: done, clean");
        else
            $display("quadratic_probe_hash_table_test: done, errors");
        $finish;
    end

endmodule
